### rtl/ftag_pkg.sv
package ftag_pkg;

  localparam int Q_W        = 32;
  localparam int CFG_SIZE_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int ROW_W      = 12;
  localparam int DEPTH_W    = 31;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_PLANE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_U     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_V     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_U    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_V    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT  = 3'd7;

  // carried alongside the alpha division
  typedef struct packed {
    logic [DEPTH_W-1:0]  stored;
    logic signed [31:0]  numer;
    logic signed [31:0]  v_near;
    logic signed [31:0]  v_range;
    logic signed [31:0]  u_near;
    logic signed [31:0]  u_range;
    logic                q_neg;
    logic                zero_div;
    logic                num_neg;
  } alpha_side_t;

  // carried alongside the reciprocal division
  typedef struct packed {
    logic [DEPTH_W-1:0]  stored;
    logic signed [31:0]  numer;
    logic signed [31:0]  sv;
    logic signed [31:0]  su;
    logic                den_neg;
    logic                den_zero;
  } recip_side_t;

endpackage

### rtl/ftag_div_pipe.sv
// Unsigned restoring divider, one quotient bit per stage.
module ftag_div_pipe #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [PW-1:0] side_in,
  output logic          out_vld,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder,
  output logic [PW-1:0] side_out
);

  logic [NW-1:0] vld_r;
  logic [NW-1:0] num_r  [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [DW-1:0] dvs_r  [NW];
  logic [PW-1:0] side_r [NW];

  logic [NW-1:0] src_num  [NW];
  logic [DW-1:0] src_rem  [NW];
  logic [DW-1:0] src_dvs  [NW];
  logic [PW-1:0] src_side [NW];
  logic [DW:0]   part     [NW];
  logic [NW-1:0] fits;
  logic [NW-1:0] num_nxt  [NW];
  logic [DW-1:0] rem_nxt  [NW];

  always_comb begin
    src_num[0]  = dividend;
    src_rem[0]  = '0;
    src_dvs[0]  = divisor;
    src_side[0] = side_in;
    for (int s = 1; s < NW; s++) begin
      src_num[s]  = num_r[s-1];
      src_rem[s]  = rem_r[s-1];
      src_dvs[s]  = dvs_r[s-1];
      src_side[s] = side_r[s-1];
    end
    for (int s = 0; s < NW; s++) begin
      part[s]    = {src_rem[s], src_num[s][NW-1]};
      fits[s]    = part[s] >= {1'b0, src_dvs[s]};
      rem_nxt[s] = fits[s] ? DW'(part[s] - {1'b0, src_dvs[s]}) : part[s][DW-1:0];
      num_nxt[s] = {src_num[s][NW-2:0], fits[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NW; s++) begin
        num_r[s]  <= num_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        dvs_r[s]  <= src_dvs[s];
        side_r[s] <= src_side[s];
      end
    end
  end

  assign out_vld   = vld_r[NW-1];
  assign quotient  = num_r[NW-1];
  assign remainder = rem_r[NW-1];
  assign side_out  = side_r[NW-1];

endmodule

### rtl/floor_texel_address_gen_unit.sv
// Pipeline: input register, alpha divider, stages B..D, reciprocal divider, stages E..I,
//   wrap dividers, result register; the restoring dividers retire one bit per stage.
// Throughput: one request per cycle; the whole pipe holds while a result is stalled.
// Reset (rst_n low, synchronous): pipe valids and result valid clear, registers take
//   near 1.0, depth range 0, scales 1.0, offsets 0, texture 64 x 64.
module floor_texel_address_gen_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int TEX_MAX_SIDE = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [ftag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ftag_pkg::Q_W-1:0]            cfg_wdata,
  // pixel requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ftag_pkg::ROW_W-1:0]          in_row,
  input  logic [ftag_pkg::DEPTH_W-1:0]        in_stored_depth,
  input  logic signed [31:0]                  in_horizon_row,
  input  logic signed [31:0]                  in_row_span,
  input  logic signed [31:0]                  in_depth_numer,
  input  logic signed [31:0]                  in_tex_v_near,
  input  logic signed [31:0]                  in_tex_v_range,
  input  logic signed [31:0]                  in_tex_u_near,
  input  logic signed [31:0]                  in_tex_u_range,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_draw,
  output logic [ftag_pkg::DEPTH_W-1:0]        out_new_depth,
  output logic [9:0]                          out_tex_col,
  output logic [9:0]                          out_tex_row,
  output logic [19:0]                         out_texel_index
);

  localparam int F      = FRAC_BITS;
  localparam int SZW_R  = $clog2(TEX_MAX_SIDE + 1);
  // effective size never exceeds what the 11-bit register holds
  localparam int SZW    = (SZW_R > ftag_pkg::CFG_SIZE_W) ? ftag_pkg::CFG_SIZE_W : SZW_R;
  localparam int NW0    = (((ftag_pkg::ROW_W + F) > 31) ? (ftag_pkg::ROW_W + F) : 31) + 2;
  localparam int AW     = NW0 + F;          // alpha dividend width
  localparam int RW     = 2 * F + 1;        // reciprocal dividend width
  localparam int MW     = (((SZW + F) > 31) ? (SZW + F) : 31) + 2;  // mirrored coord
  localparam int MQW    = MW - F;           // integer part of mirrored coord
  localparam int IXW    = 2 * SZW + 1;

  localparam logic signed [31:0] ONE_Q   = 32'(64'(1) << F);
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;
  localparam logic [RW-1:0]      RD_NUM  = RW'(1) << (2 * F);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > S32_MAX) begin
      return Q_MAX;
    end else if (x < S32_MIN) begin
      return Q_MIN;
    end
    return x[31:0];
  endfunction

  // Q product back to Q: floor shift then saturate
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    return sat32(p >>> F);
  endfunction

  function automatic logic [SZW-1:0] clamp_size(input logic [ftag_pkg::CFG_SIZE_W-1:0] v);
    if (v == '0) begin
      return SZW'(1);
    end else if (int'(v) > TEX_MAX_SIDE) begin
      return SZW'(TEX_MAX_SIDE);
    end
    return SZW'(v);
  endfunction

  // |size - t| integer part; an in-range value is below size and so is its own remainder
  function automatic logic [MQW-1:0] wrap_q(input logic [SZW-1:0] size,
                                            input logic signed [31:0] t);
    logic signed [MW-1:0] m;
    logic [MW-1:0]        mag;
    m   = $signed(MW'(size) << F) - MW'(t);
    mag = m[MW-1] ? (~m + 1'b1) : m;
    return MQW'(mag >> F);
  endfunction

  // Turn a magnitude quotient into a saturated signed Q value
  function automatic logic signed [31:0] sat_quot(input logic big, input logic neg,
                                                  input logic [31:0] low);
    if (big) begin
      return neg ? Q_MIN : Q_MAX;
    end
    return neg ? (~low + 32'd1) : low;
  endfunction

  // ---------------------------------------------------------------- registers
  logic signed [31:0]               near_plane_r, depth_range_r;
  logic signed [31:0]               scale_u_r, scale_v_r, offset_u_r, offset_v_r;
  logic [ftag_pkg::CFG_SIZE_W-1:0]  tex_width_r, tex_height_r;
  logic [SZW-1:0]                   w_size, h_size;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_plane_r  <= ONE_Q;
      depth_range_r <= '0;
      scale_u_r     <= ONE_Q;
      scale_v_r     <= ONE_Q;
      offset_u_r    <= '0;
      offset_v_r    <= '0;
      tex_width_r   <= 11'd64;
      tex_height_r  <= 11'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        ftag_pkg::REG_NEAR_PLANE:  near_plane_r  <= cfg_wdata;
        ftag_pkg::REG_DEPTH_RANGE: depth_range_r <= cfg_wdata;
        ftag_pkg::REG_SCALE_U:     scale_u_r     <= cfg_wdata;
        ftag_pkg::REG_SCALE_V:     scale_v_r     <= cfg_wdata;
        ftag_pkg::REG_OFFSET_U:    offset_u_r    <= cfg_wdata;
        ftag_pkg::REG_OFFSET_V:    offset_v_r    <= cfg_wdata;
        ftag_pkg::REG_TEX_WIDTH:   tex_width_r   <= cfg_wdata[ftag_pkg::CFG_SIZE_W-1:0];
        ftag_pkg::REG_TEX_HEIGHT:  tex_height_r  <= cfg_wdata[ftag_pkg::CFG_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_size = clamp_size(tex_width_r);
  assign h_size = clamp_size(tex_height_r);

  // ---------------------------------------------------------------- flow control
  // One enable for every stage: the pipe moves unless the result register is held.
  logic adv;
  logic out_valid_r;

  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------- stage A: input register
  logic                         a_vld_r;
  logic [ftag_pkg::ROW_W-1:0]   a_row_r;
  logic [ftag_pkg::DEPTH_W-1:0] a_stored_r;
  logic signed [31:0]           a_horizon_r, a_span_r, a_numer_r;
  logic signed [31:0]           a_v_near_r, a_v_range_r, a_u_near_r, a_u_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_row_r     <= in_row;
      a_stored_r  <= in_stored_depth;
      a_horizon_r <= in_horizon_row;
      a_span_r    <= in_row_span;
      a_numer_r   <= in_depth_numer;
      a_v_near_r  <= in_tex_v_near;
      a_v_range_r <= in_tex_v_range;
      a_u_near_r  <= in_tex_u_near;
      a_u_range_r <= in_tex_u_range;
    end
  end

  // alpha dividend (row - horizon) scaled twice, split into sign and magnitude
  logic signed [AW-1:0]   a_num;
  logic [AW-1:0]          a_num_mag;
  logic [31:0]            a_span_mag;
  ftag_pkg::alpha_side_t  a_side;

  always_comb begin
    a_num      = ($signed(AW'(a_row_r)) <<< (2 * F)) - (AW'(a_horizon_r) <<< F);
    a_num_mag  = a_num[AW-1] ? (~a_num + 1'b1) : a_num;
    a_span_mag = a_span_r[31] ? (~a_span_r + 32'd1) : a_span_r;
    a_side.stored   = a_stored_r;
    a_side.numer    = a_numer_r;
    a_side.v_near   = a_v_near_r;
    a_side.v_range  = a_v_range_r;
    a_side.u_near   = a_u_near_r;
    a_side.u_range  = a_u_range_r;
    a_side.q_neg    = a_num[AW-1] ^ a_span_r[31];
    a_side.zero_div = (a_span_r == '0);
    a_side.num_neg  = a_num[AW-1];
  end

  // ---------------------------------------------------------------- alpha division
  logic                  d1_vld;
  logic [AW-1:0]         d1_quot;
  ftag_pkg::alpha_side_t d1_side;

  ftag_div_pipe #(
    .NW ( AW ),
    .DW ( 32 ),
    .PW ( $bits(ftag_pkg::alpha_side_t) )
  ) u_div_alpha (
    .clk       ( clk        ),
    .rst_n     ( rst_n      ),
    .adv       ( adv        ),
    .in_vld    ( a_vld_r    ),
    .dividend  ( a_num_mag  ),
    .divisor   ( a_span_mag ),
    .side_in   ( a_side     ),
    .out_vld   ( d1_vld     ),
    .quotient  ( d1_quot    ),
    .remainder (            ),
    .side_out  ( d1_side    )
  );

  // ---------------------------------------------------------------- stage B: alpha
  logic                  b_vld_r;
  logic signed [31:0]    b_alpha_r, b_alpha_nxt;
  ftag_pkg::alpha_side_t b_side_r;

  always_comb begin
    if (d1_side.zero_div) begin
      b_alpha_nxt = d1_side.num_neg ? Q_MIN : Q_MAX;
    end else begin
      b_alpha_nxt = sat_quot((d1_quot >> 31) != '0, d1_side.q_neg, 32'(d1_quot));
    end
  end

  // ---------------------------------------------------------------- stage C: alpha products
  logic                  c_vld_r;
  logic signed [63:0]    c_pden_r, c_pv_r, c_pu_r;
  ftag_pkg::alpha_side_t c_side_r;

  // ---------------------------------------------------------------- stage D: sums
  logic                  d_vld_r;
  logic signed [31:0]    d_den_r, d_sv_r, d_su_r;
  ftag_pkg::alpha_side_t d_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= d1_vld;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_alpha_r <= b_alpha_nxt;
      b_side_r  <= d1_side;
      c_pden_r  <= b_alpha_r * depth_range_r;
      c_pv_r    <= b_alpha_r * b_side_r.v_range;
      c_pu_r    <= b_alpha_r * b_side_r.u_range;
      c_side_r  <= b_side_r;
      d_den_r   <= sat32(64'(near_plane_r) + 64'(qscale(c_pden_r)));
      d_sv_r    <= sat32(64'(c_side_r.v_near) + 64'(qscale(c_pv_r)));
      d_su_r    <= sat32(64'(c_side_r.u_near) + 64'(qscale(c_pu_r)));
      d_side_r  <= c_side_r;
    end
  end

  logic [31:0]           d_den_mag;
  ftag_pkg::recip_side_t d_rside;

  always_comb begin
    d_den_mag        = d_den_r[31] ? (~d_den_r + 32'd1) : d_den_r;
    d_rside.stored   = d_side_r.stored;
    d_rside.numer    = d_side_r.numer;
    d_rside.sv       = d_sv_r;
    d_rside.su       = d_su_r;
    d_rside.den_neg  = d_den_r[31];
    d_rside.den_zero = (d_den_r == '0);
  end

  // ---------------------------------------------------------------- reciprocal division
  logic                  d2_vld;
  logic [RW-1:0]         d2_quot;
  ftag_pkg::recip_side_t d2_side;

  ftag_div_pipe #(
    .NW ( RW ),
    .DW ( 32 ),
    .PW ( $bits(ftag_pkg::recip_side_t) )
  ) u_div_recip (
    .clk       ( clk       ),
    .rst_n     ( rst_n     ),
    .adv       ( adv       ),
    .in_vld    ( d_vld_r   ),
    .dividend  ( RD_NUM    ),
    .divisor   ( d_den_mag ),
    .side_in   ( d_rside   ),
    .out_vld   ( d2_vld    ),
    .quotient  ( d2_quot   ),
    .remainder (           ),
    .side_out  ( d2_side   )
  );

  // ---------------------------------------------------------------- stages E..I
  logic                         e_vld_r, f_vld_r, g_vld_r, h_vld_r, i_vld_r;
  logic signed [31:0]           e_rdiv_r, e_rdiv_nxt;
  ftag_pkg::recip_side_t        e_side_r;
  logic signed [63:0]           f_pz_r, f_pv_r, f_pu_r;
  logic [ftag_pkg::DEPTH_W-1:0] f_stored_r;
  logic signed [31:0]           g_z_r, g_cv_r, g_cu_r, g_z_nxt;
  logic                         g_draw_r, g_draw_nxt;
  logic signed [32:0]           g_thresh;
  logic signed [63:0]           h_pv_r, h_pu_r;
  logic signed [31:0]           h_z_r, i_z_r;
  logic                         h_draw_r, i_draw_r;
  logic signed [31:0]           i_tv_r, i_tu_r;

  always_comb begin
    // a zero denominator with the positive dividend saturates high
    if (d2_side.den_zero) begin
      e_rdiv_nxt = Q_MAX;
    end else begin
      e_rdiv_nxt = sat_quot((d2_quot >> 31) != '0, d2_side.den_neg, 32'(d2_quot));
    end
    g_z_nxt    = qscale(f_pz_r);
    g_thresh   = $signed({2'b00, f_stored_r}) - 33'(ONE_Q);
    g_draw_nxt = $signed({g_z_nxt[31], g_z_nxt}) < g_thresh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= d2_vld;
      f_vld_r <= e_vld_r;
      g_vld_r <= f_vld_r;
      h_vld_r <= g_vld_r;
      i_vld_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_rdiv_r   <= e_rdiv_nxt;
      e_side_r   <= d2_side;
      // perspective products against the reciprocal
      f_pz_r     <= e_side_r.numer * e_rdiv_r;
      f_pv_r     <= e_side_r.sv * e_rdiv_r;
      f_pu_r     <= e_side_r.su * e_rdiv_r;
      f_stored_r <= e_side_r.stored;
      g_z_r      <= g_z_nxt;
      g_cv_r     <= qscale(f_pv_r);
      g_cu_r     <= qscale(f_pu_r);
      g_draw_r   <= g_draw_nxt;
      // texture scale
      h_pv_r     <= g_cv_r * scale_v_r;
      h_pu_r     <= g_cu_r * scale_u_r;
      h_z_r      <= g_z_r;
      h_draw_r   <= g_draw_r;
      // texture offset
      i_tv_r     <= sat32(64'(qscale(h_pv_r)) + 64'(offset_v_r));
      i_tu_r     <= sat32(64'(qscale(h_pu_r)) + 64'(offset_u_r));
      i_z_r      <= h_z_r;
      i_draw_r   <= h_draw_r;
    end
  end

  // ---------------------------------------------------------------- mirror and wrap
  logic [MQW-1:0]               i_qu, i_qv;
  logic [ftag_pkg::DEPTH_W-1:0] i_new_depth;

  assign i_qu        = wrap_q(w_size, i_tu_r);
  assign i_qv        = wrap_q(h_size, i_tv_r);
  assign i_new_depth = i_z_r[31] ? '0 : i_z_r[ftag_pkg::DEPTH_W-1:0];

  logic                         mu_vld, mv_vld;
  logic [SZW-1:0]               mu_rem, mv_rem;
  logic [ftag_pkg::DEPTH_W-1:0] mu_depth;
  logic                         mv_draw;

  ftag_div_pipe #(
    .NW ( MQW ),
    .DW ( SZW ),
    .PW ( ftag_pkg::DEPTH_W )
  ) u_mod_u (
    .clk       ( clk         ),
    .rst_n     ( rst_n       ),
    .adv       ( adv         ),
    .in_vld    ( i_vld_r     ),
    .dividend  ( i_qu        ),
    .divisor   ( w_size      ),
    .side_in   ( i_new_depth ),
    .out_vld   ( mu_vld      ),
    .quotient  (             ),
    .remainder ( mu_rem      ),
    .side_out  ( mu_depth    )
  );

  ftag_div_pipe #(
    .NW ( MQW ),
    .DW ( SZW ),
    .PW ( 1 )
  ) u_mod_v (
    .clk       ( clk      ),
    .rst_n     ( rst_n    ),
    .adv       ( adv      ),
    .in_vld    ( i_vld_r  ),
    .dividend  ( i_qv     ),
    .divisor   ( h_size   ),
    .side_in   ( i_draw_r ),
    .out_vld   ( mv_vld   ),
    .quotient  (          ),
    .remainder ( mv_rem   ),
    .side_out  ( mv_draw  )
  );

  // ---------------------------------------------------------------- result register
  logic [2*SZW-1:0]             idx_prod;
  logic [IXW-1:0]               idx_sum;
  logic                         out_draw_r;
  logic [ftag_pkg::DEPTH_W-1:0] out_new_depth_r;
  logic [9:0]                   out_tex_col_r, out_tex_row_r;
  logic [19:0]                  out_texel_index_r;

  assign idx_prod = w_size * mv_rem;
  assign idx_sum  = {1'b0, idx_prod} + IXW'(mu_rem);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mu_vld;
    end
  end

  // a failed depth test still reports the depth, texel fields read zero
  always_ff @(posedge clk) begin
    if (adv) begin
      out_draw_r        <= mv_draw;
      out_new_depth_r   <= mu_depth;
      out_tex_col_r     <= mv_draw ? 10'(mu_rem) : '0;
      out_tex_row_r     <= mv_draw ? 10'(mv_rem) : '0;
      out_texel_index_r <= mv_draw ? 20'(idx_sum) : '0;
    end
  end

  assign out_draw        = out_draw_r;
  assign out_new_depth   = out_new_depth_r;
  assign out_tex_col     = out_tex_col_r;
  assign out_tex_row     = out_tex_row_r;
  assign out_texel_index = out_texel_index_r;

`ifndef SYNTH
  // both wrap lanes move in lock step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    mu_vld == mv_vld)
    else $error("wrap lanes out of step");

  // a held result must hold the whole pipe and the input
  a_hold_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> in_stall)
    else $error("input taken while result held");

  a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_draw_r) |->
      (out_tex_col_r == '0 && out_tex_row_r == '0 && out_texel_index_r == '0))
    else $error("texel fields set on failed depth test");

  a_col_in_texture: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_draw_r) |-> (32'(out_tex_col_r) < 32'(w_size)))
    else $error("texel column beyond texture width");
`endif

endmodule

### sim/tb_floor_texel_address_gen_unit.sv
`timescale 1ns / 1ps
module tb_floor_texel_address_gen_unit;

  localparam int FRAC = 16;
  localparam int MAX_SIDE = 1024;
  localparam int LATENCY = 109;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ftag_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ftag_pkg::Q_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ftag_pkg::ROW_W-1:0] in_row = '0;
  logic [ftag_pkg::DEPTH_W-1:0] in_stored_depth = '0;
  logic signed [31:0] in_horizon_row = '0, in_row_span = '0, in_depth_numer = '0;
  logic signed [31:0] in_tex_v_near = '0, in_tex_v_range = '0;
  logic signed [31:0] in_tex_u_near = '0, in_tex_u_range = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_draw;
  logic [ftag_pkg::DEPTH_W-1:0] out_new_depth;
  logic [9:0] out_tex_col, out_tex_row;
  logic [19:0] out_texel_index;

  // one expected pixel result
  typedef struct packed {
    logic        draw;
    logic [30:0] depth;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [19:0] index;
  } texel_res_t;

  texel_res_t texel_q[$];
  logic signed [31:0] near_r, drange_r, scu_r, scv_r, offu_r, offv_r;
  logic [10:0] texw_r, texh_r;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  longint cycles = 0;

  floor_texel_address_gen_unit u_top (.*);

  always #2 clk = ~clk;

  // ---- fixed-point helpers ----
  function automatic longint sat(input longint x);
    if (x > S_MAX) return S_MAX;
    if (x < S_MIN) return S_MIN;
    return x;
  endfunction

  // floor shift: >>> on signed longint is arithmetic
  function automatic longint qmult(input longint a, input longint b);
    return sat((a * b) >>> FRAC);
  endfunction

  function automatic longint qdivide(input longint n, input longint d);
    if (d == 0) return (n >= 0) ? S_MAX : S_MIN;
    return sat(n / d);   // SV division truncates toward zero
  endfunction

  function automatic longint side_of(input logic [10:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  // mirror as size - t, then wrap
  function automatic longint fold_coord(input longint t, input longint sz);
    longint lim, m, r;
    lim = sz <<< FRAC;
    m = lim - t;
    if (m >= 0 && m < lim) return m >>> FRAC;
    r = (m / (64'sd1 <<< FRAC)) % sz;
    return (r < 0) ? -r : r;
  endfunction

  function automatic texel_res_t texel_predict(
      input logic [11:0] row, input logic [30:0] stored,
      input logic signed [31:0] horizon, span, numer, vn, vr, un, ur);
    texel_res_t res;
    longint alpha, den, rdiv, z, cu, cv, tu, tv, w, h, col, trow;
    w = side_of(texw_r);
    h = side_of(texh_r);
    alpha = qdivide(((longint'(row) <<< FRAC) - horizon) <<< FRAC, span);
    den = sat(longint'(near_r) + qmult(alpha, drange_r));
    rdiv = qdivide(64'sd1 <<< (2 * FRAC), den);
    z = qmult(numer, rdiv);
    res = '0;
    res.draw = z < (longint'(stored) - (64'sd1 <<< FRAC));
    res.depth = (z < 0) ? '0 : z[30:0];
    if (res.draw) begin
      cv = qmult(sat(longint'(vn) + qmult(alpha, vr)), rdiv);
      cu = qmult(sat(longint'(un) + qmult(alpha, ur)), rdiv);
      tv = sat(qmult(cv, scv_r) + offv_r);
      tu = sat(qmult(cu, scu_r) + offu_r);
      trow = fold_coord(tv, h);
      col = fold_coord(tu, w);
      res.col = col[9:0];
      res.row = trow[9:0];
      res.index = 20'(col + w * trow);
    end
    return res;
  endfunction

  // ---- stimulus plumbing ----
  // valid stays high on return so a following request can go out back to back
  task automatic send_pixel(input logic [11:0] row, input logic [30:0] stored,
      input logic signed [31:0] horizon, span, numer, vn, vr, un, ur);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_row <= row; in_stored_depth <= stored; in_horizon_row <= horizon;
    in_row_span <= span; in_depth_numer <= numer;
    in_tex_v_near <= vn; in_tex_v_range <= vr;
    in_tex_u_near <= un; in_tex_u_range <= ur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    texel_q.push_back(texel_predict(row, stored, horizon, span, numer, vn, vr, un, ur));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [ftag_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    case (idx)
      ftag_pkg::REG_NEAR_PLANE:  near_r = val;
      ftag_pkg::REG_DEPTH_RANGE: drange_r = val;
      ftag_pkg::REG_SCALE_U:     scu_r = val;
      ftag_pkg::REG_SCALE_V:     scv_r = val;
      ftag_pkg::REG_OFFSET_U:    offu_r = val;
      ftag_pkg::REG_OFFSET_V:    offv_r = val;
      ftag_pkg::REG_TEX_WIDTH:   texw_r = val[10:0];
      default:                   texh_r = val[10:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // wait for the pipe to empty before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (texel_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_q();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(8 << FRAC)) - (4 << FRAC));
      default: return $urandom;
    endcase
  endfunction

  // mostly a plausible floor pixel (horizon above row, positive span and depth terms), else random fields
  task automatic send_floor_pixel();
    logic [11:0] row;
    logic [30:0] stored;
    row = $urandom_range(4095);
    stored = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(200 << FRAC));
    if ($urandom_range(9) < 8)
      send_pixel(row, stored, 32'($urandom_range(row) << FRAC),
                 32'(($urandom_range(512) + 1) << FRAC), 32'($urandom_range(64 << FRAC)),
                 32'($urandom_range(64 << FRAC)), 32'($signed($urandom_range(1 << 20)) - (1 << 19)),
                 32'($urandom_range(64 << FRAC)), 32'($signed($urandom_range(1 << 20)) - (1 << 19)));
    else
      send_pixel(12'($urandom), 31'($urandom), rnd_q(), rnd_q(), rnd_q(), rnd_q(), rnd_q(),
                 rnd_q(), rnd_q());
  endtask

  // ---- result checker ----
  always @(posedge clk) begin
    texel_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (texel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result draw=%0b", out_draw);
      end else begin
        exp_r = texel_q.pop_front();
        if (out_draw !== exp_r.draw || out_new_depth !== exp_r.depth ||
            out_tex_col !== exp_r.col || out_tex_row !== exp_r.row ||
            out_texel_index !== exp_r.index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp d=%0b z=%h c=%0d r=%0d i=%0d got d=%0b z=%h c=%0d r=%0d i=%0d",
                     exp_r.draw, exp_r.depth, exp_r.col, exp_r.row, exp_r.index, out_draw,
                     out_new_depth, out_tex_col, out_tex_row, out_texel_index);
        end
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else
      out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("floor_texel_address_gen_unit test failed");
      $finish;
    end
  end

  // ---- tests ----
  task automatic test_directed();
    send_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0);                         // zero span
    send_pixel(12'hfff, 31'h7fffffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_pixel(100, 31'h7fffffff, 50 << 16, 100 << 16, 10 << 16, 3 << 16, 1 << 16,
               5 << 16, 2 << 16);
    send_pixel(100, 31'h7fffffff, 50 << 16, 100 << 16, -(10 << 16), -(300 << 16), 1 << 16,
               900 << 16, 2 << 16);                                // negative depth, wrap
    send_pixel(100, 1 << 16, 50 << 16, 100 << 16, 10 << 16, 0, 0, 0, 0); // depth fail
    send_pixel(12'hfff, 31'h7fffffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
  endtask

  task automatic test_zero_denominator();
    write_reg(ftag_pkg::REG_NEAR_PLANE, 0);
    write_reg(ftag_pkg::REG_DEPTH_RANGE, 0);
    send_pixel(10, 31'h7fffffff, 0, 1 << 16, 1 << 16, 1 << 16, 0, 1 << 16, 0);
    send_pixel(10, 31'h7fffffff, 0, 1 << 16, -(1 << 16), 1 << 16, 0, 1 << 16, 0);
    drain();
  endtask

  task automatic config_phase(input int n);
    write_reg(ftag_pkg::REG_NEAR_PLANE,
              $urandom_range(3) == 0 ? rnd_q() : $urandom_range(4 << 16));
    write_reg(ftag_pkg::REG_DEPTH_RANGE,
              $urandom_range(3) == 0 ? rnd_q() : $urandom_range(1 << 20));
    write_reg(ftag_pkg::REG_SCALE_U, rnd_q());
    write_reg(ftag_pkg::REG_SCALE_V, rnd_q());
    write_reg(ftag_pkg::REG_OFFSET_U, rnd_q());
    write_reg(ftag_pkg::REG_OFFSET_V, rnd_q());
    case ($urandom_range(3))
      0: begin
        write_reg(ftag_pkg::REG_TEX_WIDTH, 0);
        write_reg(ftag_pkg::REG_TEX_HEIGHT, 11'h7ff);
      end
      1: begin
        write_reg(ftag_pkg::REG_TEX_WIDTH, 1024);
        write_reg(ftag_pkg::REG_TEX_HEIGHT, 1);
      end
      default: begin
        write_reg(ftag_pkg::REG_TEX_WIDTH, $urandom_range(2047));
        write_reg(ftag_pkg::REG_TEX_HEIGHT, $urandom_range(2047));
      end
    endcase
    repeat (n) send_floor_pixel();
    drain();
  endtask

  task automatic test_random_idling();
    sender_idle_pct = 0;  recv_stall_pct = 0;  config_phase(60);
    sender_idle_pct = 47; recv_stall_pct = 0;  config_phase(60);
    sender_idle_pct = 0;  recv_stall_pct = 47; config_phase(60);
    sender_idle_pct = 28; recv_stall_pct = 28; config_phase(60);
    sender_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (200) send_floor_pixel();
    drain();
  endtask

  initial begin
    near_r = 32'sd65536; drange_r = 0; scu_r = 32'sd65536; scv_r = 32'sd65536;
    offu_r = 0; offv_r = 0; texw_r = 64; texh_r = 64;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    drain();
    test_zero_denominator();
    test_random_idling();
    test_backpressure();
    if (mismatches == 0 && texel_q.size() == 0)
      $display("floor_texel_address_gen_unit test passed");
    else
      $display("floor_texel_address_gen_unit test failed");
    $finish;
  end

endmodule
